// File: src/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg: shared types and constants for the tilt LED bar core
// Field widths, filter constants, register codes and the LED pattern lookup.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int unsigned Taps       = 5;
  localparam int unsigned SampleW    = 13;
  localparam int unsigned LedW       = 8;
  localparam int unsigned LevelW     = 5;
  localparam int unsigned OffsetW    = 9;
  localparam int unsigned PeriodW    = 5;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 9;

  localparam int unsigned FiltGain   = 2;
  localparam int unsigned FiltDiv    = 10;
  localparam int unsigned Divisor    = FiltDiv / FiltGain;

  // sum / Divisor as (|sum| * RecipM) >> RecipShift, exact for |sum| < 2**18
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipM     = (2 ** RecipShift + Divisor - 1) / Divisor;
  localparam int unsigned RecipW     = $clog2(RecipM + 1);

  localparam int unsigned SumW       = SampleW + $clog2(Taps);

  localparam int unsigned FiltMax    = 4095;
  localparam int unsigned FiltMinMag = 4096;

  localparam logic signed [OffsetW-1:0] OffsetRst = -9'sd32;
  localparam logic [PeriodW-1:0]        PeriodRst = 5'd16;

  typedef enum logic [0:0] {
    CmdSample = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOffset = 1'b0,
    CfgPeriod = 1'b1
  } cfg_idx_e;

  function automatic logic [LedW-1:0] pattern_lut(input logic [2:0] sel);
    logic [LedW-1:0] pat;
    case (sel)
      3'd0:    pat = 8'h08;
      3'd1:    pat = 8'h04;
      3'd2:    pat = 8'h02;
      3'd3:    pat = 8'h01;
      3'd4:    pat = 8'h80;
      3'd5:    pat = 8'h40;
      3'd6:    pat = 8'h20;
      default: pat = 8'h10;
    endcase
    return pat;
  endfunction

endpackage

// File: src/tlb_in_if.sv
// ----------------------------------------------------------------------------
// tlb_in_if: request channel of the tilt LED bar core
// Carries a command (sample or tick) and a signed accelerometer reading.
// ----------------------------------------------------------------------------
interface tlb_in_if;
  import tlb_pkg::*;

  logic                       valid;
  logic                       ready;
  cmd_e                       command;
  logic signed [SampleW-1:0]  sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);

endinterface

// File: src/tlb_out_if.sv
// ----------------------------------------------------------------------------
// tlb_out_if: result channel of the tilt LED bar core
// Carries the LED drive, the filtered reading and the duty level.
// ----------------------------------------------------------------------------
interface tlb_out_if;
  import tlb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [LedW-1:0]            led_drive;
  logic signed [SampleW-1:0]  filtered;
  logic [LevelW-1:0]          duty_level;

  modport source (output valid, output led_drive, output filtered, output duty_level,
                  input ready);
  modport sink   (input valid, input led_drive, input filtered, input duty_level,
                  output ready);

endinterface

// File: src/tilt_led_bar_fir_pwm_core.sv
// ----------------------------------------------------------------------------
// tilt_led_bar_fir_pwm_core: tilt-driven LED bar with PWM dimming
// Five-tap moving average of accelerometer samples selects an LED pattern
// and duty level; tick requests step the PWM counter.
// ----------------------------------------------------------------------------
// One request is accepted every clock cycle while the result side is not
// stalled, and every request gives exactly one result. A request is held in
// an input register, then the filter sum, the divide-by-five (reciprocal
// multiply) and the PWM update run combinationally into the result register,
// which loads when it is empty or its result is being taken. Configuration
// writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at the next edge.
// ----------------------------------------------------------------------------
module tilt_led_bar_fir_pwm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tlb_in_if.sink                        req_i,
  tlb_out_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [tlb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tlb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tlb_pkg::*;

  logic signed [OffsetW-1:0] offset_q;
  logic [PeriodW-1:0]        period_q;

  logic                      s1_valid_q;
  cmd_e                      s1_cmd_q;
  logic signed [SampleW-1:0] s1_sample_q;

  logic [LedW-1:0]           base_q, base_d;
  logic [LevelW-1:0]         level_q, level_d;
  logic [PeriodW-1:0]        count_q, count_d;
  logic signed [SampleW-1:0] filt_q, filt_d;

  logic                      out_valid_q;
  logic [LedW-1:0]           out_led_q, led_d;
  logic signed [SampleW-1:0] out_filt_q;
  logic [LevelW-1:0]         out_duty_q;

  logic                      req_acc;
  logic                      adv;
  logic                      is_sample;
  logic signed [SampleW-1:0] filt_c;
  logic [OffsetW-1:0]        adj_c;

  assign adv        = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || adv;
  assign req_acc    = req_i.valid && req_i.ready;
  assign is_sample  = (s1_cmd_q == CmdSample);

  tlb_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (adv && is_sample),
    .sample_i   (s1_sample_q),
    .filtered_o (filt_c)
  );

  assign adj_c = filt_c[OffsetW-1:0] + offset_q;

  always_comb begin
    base_d  = base_q;
    level_d = level_q;
    count_d = count_q;
    filt_d  = filt_q;
    if (is_sample) begin
      base_d  = pattern_lut(adj_c[8:6]);
      level_d = adj_c[5:1];
      filt_d  = filt_c;
      led_d   = base_d;
    end else begin
      led_d = (count_q < level_q) ? (base_q >> 1) : base_q;
      if (count_q > period_q) begin
        count_d = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetRst;
      period_q <= PeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgOffset: offset_q <= $signed(cfg_data_i[OffsetW-1:0]);
        CfgPeriod: period_q <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_cmd_q    <= req_i.command;
      s1_sample_q <= req_i.sample;
    end
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      level_q <= '0;
      count_q <= '0;
      filt_q  <= '0;
    end else if (adv) begin
      base_q  <= base_d;
      level_q <= level_d;
      count_q <= count_d;
      filt_q  <= filt_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_led_q  <= led_d;
      out_filt_q <= filt_d;
      out_duty_q <= level_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.led_drive  = out_led_q;
  assign rsp_o.filtered   = out_filt_q;
  assign rsp_o.duty_level = out_duty_q;

  a_tick_steps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !is_sample |=> count_q != $past(count_q))
    else $error("tick did not step the PWM counter");

  a_tick_keeps_filt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !is_sample |=> $stable(filt_q) && $stable(level_q) && $stable(base_q))
    else $error("tick changed filter state");

  a_sample_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_sample |=> $onehot(rsp_o.led_drive))
    else $error("sample result pattern not one-hot");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while both stages are full");

endmodule

// File: src/tlb_filter.sv
// ----------------------------------------------------------------------------
// tlb_filter: moving-average history and divider
// Holds the sample history; gives the saturated sum/5 of the history with the
// incoming sample shifted in, and commits the shift when enabled.
// ----------------------------------------------------------------------------
module tlb_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_en_i,
  input  logic signed [tlb_pkg::SampleW-1:0] sample_i,
  output logic signed [tlb_pkg::SampleW-1:0] filtered_o
);
  import tlb_pkg::*;

  localparam int unsigned ProdW = SumW + RecipW;

  logic signed [SampleW-1:0] hist_q [Taps];
  logic signed [SampleW-1:0] hist_d [Taps];
  logic signed [SumW-1:0]    sum_c;
  logic                      neg_c;
  logic [SumW-1:0]           mag_c;
  logic [ProdW-1:0]          prod_c;
  logic [31:0]               quo_c;

  always_comb begin
    hist_d[0] = sample_i;
    for (int i = 1; i < Taps; i++) begin
      hist_d[i] = hist_q[i-1];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < Taps; i++) begin
      sum_c = sum_c + SumW'(hist_d[i]);
    end
  end

  assign neg_c  = sum_c[SumW-1];
  assign mag_c  = neg_c ? (~sum_c + 1'b1) : sum_c;
  assign prod_c = ProdW'(mag_c) * ProdW'(RecipM);
  assign quo_c  = 32'(prod_c[ProdW-1:RecipShift]);

  always_comb begin
    if (neg_c) begin
      if (quo_c > 32'(FiltMinMag)) begin
        filtered_o = -13'sd4096;
      end else begin
        filtered_o = -$signed(quo_c[SampleW-1:0]);
      end
    end else begin
      if (quo_c > 32'(FiltMax)) begin
        filtered_o = 13'sd4095;
      end else begin
        filtered_o = $signed(quo_c[SampleW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) begin
        hist_q[i] <= '0;
      end
    end else if (shift_en_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

// File: verif/tilt_led_bar_fir_pwm_core_test.sv
// ----------------------------------------------------------------------------
// tilt_led_bar_fir_pwm_core_test: self-checking bench for the tilt LED bar core
// Drives sample and tick requests with random idling on both channels, keeps
// its own filter/PWM predictor and compares every result in order. Runs a
// directed table first, then random traffic over several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tilt_led_bar_fir_pwm_core_test;
  import tlb_pkg::*;

  localparam int unsigned PhaseItems  = 333;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [LedW-1:0]    led;
    logic [SampleW-1:0] filt;
    logic [LevelW-1:0]  lvl;
  } led_result_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [SampleW-1:0] smp;
    logic               typed;
    led_result_t        want;
  } stim_row_t;

  localparam logic [LedW-1:0] LedMap [8] = '{
    8'h08, 8'h04, 8'h02, 8'h01, 8'h80, 8'h40, 8'h20, 8'h10
  };

  // typed rows: reset state, idle ticks, filter at both rails
  localparam stim_row_t DirRows [24] = '{
    '{CmdTick,   13'h0000, 1'b1, '{8'h00, 13'h0000, 5'd0}},
    '{CmdTick,   13'h1000, 1'b1, '{8'h00, 13'h0000, 5'd0}},
    '{CmdSample, 13'h0000, 1'b1, '{8'h10, 13'h0000, 5'd16}},
    '{CmdSample, 13'h0fff, 1'b0, '0},
    '{CmdSample, 13'h0fff, 1'b0, '0},
    '{CmdSample, 13'h0fff, 1'b0, '0},
    '{CmdSample, 13'h0fff, 1'b0, '0},
    '{CmdSample, 13'h0fff, 1'b1, '{8'h10, 13'h0fff, 5'd15}},
    '{CmdTick,   13'h0000, 1'b0, '0},
    '{CmdTick,   13'h1555, 1'b0, '0},
    '{CmdSample, 13'h1000, 1'b0, '0},
    '{CmdSample, 13'h1000, 1'b0, '0},
    '{CmdSample, 13'h1000, 1'b0, '0},
    '{CmdSample, 13'h1000, 1'b0, '0},
    '{CmdSample, 13'h1000, 1'b1, '{8'h10, 13'h1000, 5'd16}},
    '{CmdTick,   13'h1fff, 1'b0, '0},
    '{CmdTick,   13'h0aaa, 1'b0, '0},
    '{CmdSample, 13'h0001, 1'b0, '0},
    '{CmdSample, 13'h1fff, 1'b0, '0},
    '{CmdSample, 13'h1ffd, 1'b0, '0},
    '{CmdSample, 13'h0aaa, 1'b0, '0},
    '{CmdSample, 13'h1555, 1'b0, '0},
    '{CmdTick,   13'h0000, 1'b0, '0},
    '{CmdTick,   13'h0000, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tlb_in_if  req_if ();
  tlb_out_if rsp_if ();

  tilt_led_bar_fir_pwm_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic signed [SampleW-1:0] tap_hist [Taps];
  logic [LedW-1:0]           bar_pattern;
  logic [LevelW-1:0]         duty_q;
  logic [PeriodW-1:0]        pwm_cnt;
  logic signed [SampleW-1:0] filt_q;
  logic signed [OffsetW-1:0] offset_q;
  logic [PeriodW-1:0]        period_q;

  led_result_t pending_leds [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic [SampleW-1:0] last_smp = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic led_result_t led_bar_next(cmd_e cmd, logic signed [SampleW-1:0] smp);
    int          acc;
    int          f;
    logic [31:0] adj;
    led_result_t r;
    if (cmd == CmdSample) begin
      for (int i = Taps - 1; i > 0; i--) tap_hist[i] = tap_hist[i-1];
      tap_hist[0] = smp;
      acc = 0;
      for (int i = 0; i < Taps; i++) acc += 2 * int'(tap_hist[i]);
      f = acc / 10;
      if (f > 4095) f = 4095;
      if (f < -4096) f = -4096;
      filt_q = f[SampleW-1:0];
      adj = f + int'(offset_q);
      bar_pattern = LedMap[adj[8:6]];
      duty_q = adj[5:1];
      r.led = bar_pattern;
    end else begin
      r.led = (pwm_cnt < duty_q) ? (bar_pattern >> 1) : bar_pattern;
      pwm_cnt = (pwm_cnt > period_q) ? '0 : pwm_cnt + 5'd1;
    end
    r.filt = filt_q;
    r.lvl = duty_q;
    return r;
  endfunction

  task automatic send_req(stim_row_t row);
    led_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= row.cmd;
    req_if.sample  <= row.smp;
    do @(posedge clk_i); while (!req_if.ready);
    r = led_bar_next(row.cmd, row.smp);
    if (row.typed) r = row.want;
    pending_leds.push_back(r);
  endtask

  task automatic send_random();
    stim_row_t row;
    row = '0;
    row.cmd = $urandom_range(1) ? CmdTick : CmdSample;
    case ($urandom_range(11))
      0:       row.smp = 13'h0fff;
      1:       row.smp = 13'h1000;
      2, 3:    row.smp = 13'($urandom_range(16)) - 13'd8;
      4, 5, 6: row.smp = last_smp;
      default: row.smp = 13'($urandom);
    endcase
    if (row.cmd == CmdSample) last_smp = row.smp;
    send_req(row);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [OffsetW-1:0] off, logic [PeriodW-1:0] per);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgOffset;
    cfg_data <= off;
    @(posedge clk_i);
    cfg_idx  <= CfgPeriod;
    cfg_data <= CfgDataW'(per);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    offset_q = off;
    period_q = per;
  endtask

  // result side: check then choose next ready
  always @(posedge clk_i) begin
    led_result_t exp_r;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_leds.size() == 0) begin
        if (err_cnt < ReportMax)
          $display("unexpected result: led %h filtered %0d level %0d",
                   rsp_if.led_drive, $signed(rsp_if.filtered), rsp_if.duty_level);
        err_cnt++;
      end else begin
        exp_r = pending_leds.pop_front();
        if (rsp_if.led_drive !== exp_r.led || rsp_if.filtered !== exp_r.filt ||
            rsp_if.duty_level !== exp_r.lvl) begin
          if (err_cnt < ReportMax)
            $display("mismatch: led %h/%h filtered %0d/%0d level %0d/%0d (exp/act)",
                     exp_r.led, rsp_if.led_drive, $signed(exp_r.filt),
                     $signed(rsp_if.filtered), exp_r.lvl, rsp_if.duty_level);
          err_cnt++;
        end
      end
    end
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [OffsetW-1:0] off;
    logic [PeriodW-1:0] per;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.command = CmdSample;
    req_if.sample  = '0;
    rsp_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgOffset;
    cfg_data       = '0;
    foreach (tap_hist[i]) tap_hist[i] = '0;
    bar_pattern = '0;
    duty_q      = '0;
    pwm_cnt     = '0;
    filt_q      = '0;
    offset_q    = OffsetRst;
    period_q    = PeriodRst;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 32;
    snk_idle_pct = 47;
    foreach (DirRows[i]) send_req(DirRows[i]);

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          src_idle_pct = 32;
          snk_idle_pct = 47;
        end
        1: begin
          src_idle_pct = 47;
          snk_idle_pct = 32;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 2; k++) begin
        case (2 * regime + k)
          0: begin
            off = 9'h100;
            per = 5'd1;
          end
          1: begin
            off = 9'h0ff;
            per = 5'd31;
          end
          2: begin
            off = 9'h000;
            per = 5'd30;
          end
          3: begin
            off = 9'h1ff;
            per = 5'd0;
          end
          default: begin
            off = 9'($urandom);
            per = 5'($urandom);
          end
        endcase
        drain();
        write_regs(off, per);
        repeat (PhaseItems) send_random();
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/tlb_pkg.sv
src/tlb_in_if.sv
src/tlb_out_if.sv
src/tlb_filter.sv
src/tilt_led_bar_fir_pwm_core.sv
verif/tilt_led_bar_fir_pwm_core_test.sv
